// ===== design/ranging_line_parser_macros.svh =====
// assertion macros shared by the ranging line parser checks
// no dependencies; guarded against repeated inclusion
`ifndef RANGING_LINE_PARSER_MACROS_SVH
`define RANGING_LINE_PARSER_MACROS_SVH

// same-cycle implication, disabled in reset
`define RLP_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ranging line parser check failed");

// next-cycle implication, disabled in reset
`define RLP_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ranging line parser check failed");

`endif

// ===== design/rlp_pkg.sv =====
// shared constants, types and character helpers for the ranging line parser
// no dependencies
package rlp_pkg;

  localparam int RLP_LINE_BYTES = 64;
  localparam int ACK_LEN        = 9;
  localparam int ACK_IDX_W      = 4;
  localparam int RANGE_DIGITS   = 6;
  localparam int TAG_DIGITS     = 4;
  localparam int RANGE_W        = 24;
  localparam int TAG_W          = 16;
  localparam int CNT_W          = 3;
  localparam int MIN_LINE       = 3;

  localparam logic KIND_BYTE     = 1'b0;
  localparam logic KIND_ACK_READ = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_F_UP  = 8'h46;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_M     = 8'h6D;

  localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;

  // acknowledgement text OK+TWLT=1
  localparam logic [7:0] ACK_TEXT [ACK_LEN] = '{
    CH_O, CH_K, CH_PLUS, CH_T, CH_W, CH_L, CH_T, CH_EQ, CH_1
  };

  typedef struct packed {
    logic start;
    logic char_vld;
    logic at_end;
  } scan_ctrl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_stat_t;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  // {digit ok, value}
  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_A_UP && c <= CH_F_UP) || (c >= CH_A_LO && c <= CH_F_LO)) begin
      r = {1'b1, c[3:0] + HEX_ALPHA_OFS};
    end
    return r;
  endfunction

endpackage

// ===== design/rlp_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module rlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rlp_ack.sv =====
// matcher for the bind acknowledgement text, with its latch
// depends on rlp_pkg
module rlp_ack (
  input  logic       clk,
  input  logic       rst,
  input  logic       feed,
  input  logic       clear,
  input  logic [7:0] data,
  output logic       latched
);
  import rlp_pkg::*;

  logic [ACK_IDX_W-1:0] idx;
  logic [ACK_IDX_W-1:0] idx_next;
  logic                 hit_all;

  always_comb begin
    hit_all  = 1'b0;
    idx_next = idx;
    if (data == ACK_TEXT[idx]) begin
      if (idx == ACK_IDX_W'(ACK_LEN - 1)) begin
        idx_next = '0;
        hit_all  = 1'b1;
      end else begin
        idx_next = idx + 1'b1;
      end
    end else begin
      // an 'O' may open a fresh match
      idx_next = (data == CH_O) ? ACK_IDX_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      latched <= 1'b0;
    end else if (feed) begin
      idx <= idx_next;
      if (hit_all) begin
        latched <= 1'b1;
      end
    end else if (clear) begin
      latched <= 1'b0;
    end
  end

endmodule

// ===== design/rlp_scan.sv =====
// character scanner: steps the line grammar one stored byte per cycle
// depends on rlp_pkg
module rlp_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  rlp_pkg::scan_ctrl_t        ctrl,
  input  logic [7:0]                 ch,
  output rlp_pkg::scan_stat_t        stat,
  output logic [rlp_pkg::TAG_W-1:0]  tag,
  output logic [rlp_pkg::RANGE_W-1:0] range_val
);
  import rlp_pkg::*;

  localparam logic [3:0] P_SEP1  = 4'd0;
  localparam logic [3:0] P_MASK  = 4'd1;
  localparam logic [3:0] P_SEP2  = 4'd2;
  localparam logic [3:0] P_RANGE = 4'd3;
  localparam logic [3:0] P_RGEND = 4'd4;
  localparam logic [3:0] P_TSEP  = 4'd5;
  localparam logic [3:0] P_TOK   = 4'd6;
  localparam logic [3:0] P_HIT   = 4'd7;
  localparam logic [3:0] P_FAIL  = 4'd8;

  logic [3:0]         phase;
  logic [3:0]         phase_next;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic [RANGE_W-1:0] range_acc;
  logic [RANGE_W-1:0] range_next;
  logic [TAG_W-1:0]   tag_acc;
  logic [TAG_W-1:0]   tag_next;
  logic               tok_ok;
  logic               tok_ok_next;
  logic [4:0]         hd;
  logic               sep;
  logic               done;

  assign done      = (phase == P_HIT) || (phase == P_FAIL);
  assign stat.done = done;
  assign stat.hit  = (phase == P_HIT);
  assign tag       = tag_acc;
  assign range_val = range_acc;

  always_comb begin
    hd          = hex_dec(ch);
    sep         = is_sep(ch);
    phase_next  = phase;
    cnt_next    = cnt;
    range_next  = range_acc;
    tag_next    = tag_acc;
    tok_ok_next = tok_ok;
    if (ctrl.start) begin
      phase_next  = P_SEP1;
      cnt_next    = '0;
      tok_ok_next = 1'b0;
    end else if (!done) begin
      if (ctrl.at_end) begin
        phase_next = P_FAIL;
      end else if (ctrl.char_vld) begin
        unique case (phase)
          P_SEP1: begin
            if (!sep) phase_next = P_MASK;
          end
          P_MASK: begin
            if (sep) phase_next = P_SEP2;
          end
          P_SEP2: begin
            if (!sep) begin
              if (hd[4]) begin
                range_next = RANGE_W'(hd[3:0]);
                cnt_next   = CNT_W'(1);
                phase_next = P_RANGE;
              end else begin
                phase_next = P_FAIL;
              end
            end
          end
          P_RANGE: begin
            if (!hd[4]) begin
              phase_next = P_FAIL;
            end else begin
              range_next = {range_acc[RANGE_W-5:0], hd[3:0]};
              if (cnt == CNT_W'(RANGE_DIGITS - 1)) begin
                phase_next = (range_next == '0) ? P_FAIL : P_RGEND;
              end else begin
                cnt_next = cnt + 1'b1;
              end
            end
          end
          P_RGEND: begin
            phase_next = sep ? P_TSEP : P_FAIL;
          end
          P_TSEP: begin
            if (!sep) begin
              tok_ok_next = (ch == CH_A_UP) || (ch == CH_A_LO);
              tag_next    = '0;
              cnt_next    = CNT_W'(1);
              phase_next  = P_TOK;
            end
          end
          P_TOK: begin
            if (sep) begin
              phase_next = P_TSEP;
            end else if (cnt == CNT_W'(TAG_DIGITS + 1)) begin
              // colon place of the token; a failed token runs on to its separator
              if (tok_ok && ch == CH_COLON) begin
                phase_next = P_HIT;
              end else begin
                tok_ok_next = 1'b0;
              end
            end else begin
              tok_ok_next = tok_ok & hd[4];
              tag_next    = {tag_acc[TAG_W-5:0], hd[3:0]};
              cnt_next    = cnt + 1'b1;
            end
          end
          default: begin
            phase_next = P_FAIL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= P_FAIL;
      cnt    <= '0;
      tok_ok <= 1'b0;
    end else begin
      phase  <= phase_next;
      cnt    <= cnt_next;
      tok_ok <= tok_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    range_acc <= range_next;
    tag_acc   <= tag_next;
  end

endmodule

// ===== design/ranging_line_parser.sv =====
// ranging line parser top level: byte intake, line buffer, scan sequencer
// depends on rlp_pkg, rlp_ram, rlp_ack, rlp_scan
//
//  channel | handshake            | fields
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | kind, rx_byte
//  out     | out_valid / out_stall| measurement_valid, tag_id, range_mm, ack_flag
//
// an ordinary byte or an acknowledgement read is accepted and its result
// registered at the same edge. a CR or LF ending a line of n >= 3 bytes starts
// a scan of the stored bytes, one per cycle through the line ram read port,
// ending early when the tag is found or the grammar fails. in_stall is high
// while scanning and while a result waits under out_stall. rst clears the
// line length, matcher and latch; the line ram needs no clearing.
module ranging_line_parser #(
  parameter int LINE_BYTES = rlp_pkg::RLP_LINE_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [7:0]                   rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         measurement_valid,
  output logic [rlp_pkg::TAG_W-1:0]    tag_id,
  output logic [rlp_pkg::RANGE_W-1:0]  range_mm,
  output logic                         ack_flag
);
  import rlp_pkg::*;

  localparam int LEN_W = $clog2(LINE_BYTES);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic               state;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   len_next;
  logic [LEN_W-1:0]   scan_end;
  logic [LEN_W-1:0]   rd_pos;
  logic               pend;
  logic               accept;
  logic               out_free;
  logic               is_eol;
  logic               restart;
  logic               keep;
  logic               we;
  logic [LEN_W-1:0]   waddr;
  logic [7:0]         rdata;
  logic               issue;
  logic               ack_latched;
  scan_ctrl_t         sctrl;
  scan_stat_t         sstat;
  logic [TAG_W-1:0]   scan_tag;
  logic [RANGE_W-1:0] scan_range;
  logic               out_load;
  logic               load_meas;
  logic [TAG_W-1:0]   load_tag;
  logic [RANGE_W-1:0] load_range;
  logic               load_ack;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);

  // line buffer update for an ordinary byte
  always_comb begin
    restart = (len == '0) ||
              (len == LEN_W'(1) && rx_byte != CH_C) ||
              (len == LEN_W'(2) && !is_sep(rx_byte)) ||
              (len >= LEN_W'(LINE_BYTES - 1));
    keep    = (rx_byte == CH_M);
    if (restart) begin
      waddr    = '0;
      len_next = keep ? LEN_W'(1) : '0;
      we       = keep;
    end else begin
      waddr    = len;
      len_next = len + 1'b1;
      we       = 1'b1;
    end
    if (rx_byte == CH_NUL) begin
      len_next = '0;
      we       = 1'b0;
    end
  end

  assign issue          = (state == S_SCAN) && !sstat.done && (rd_pos != scan_end);
  assign sctrl.start    = accept && (kind == KIND_BYTE) && is_eol &&
                          (len >= LEN_W'(MIN_LINE));
  assign sctrl.char_vld = (state == S_SCAN) && pend;
  assign sctrl.at_end   = (state == S_SCAN) && !pend && (rd_pos == scan_end);

  rlp_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line_ram (
    .clk   (clk),
    .we    (accept && (kind == KIND_BYTE) && !is_eol && we),
    .waddr (waddr),
    .wdata (rx_byte),
    .raddr (rd_pos),
    .rdata (rdata)
  );

  rlp_ack u_ack (
    .clk     (clk),
    .rst     (rst),
    .feed    (accept && (kind == KIND_BYTE)),
    .clear   (accept && (kind == KIND_ACK_READ)),
    .data    (rx_byte),
    .latched (ack_latched)
  );

  rlp_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (sctrl),
    .ch        (rdata),
    .stat      (sstat),
    .tag       (scan_tag),
    .range_val (scan_range)
  );

  // result selection
  always_comb begin
    out_load   = 1'b0;
    load_meas  = 1'b0;
    load_tag   = '0;
    load_range = '0;
    load_ack   = 1'b0;
    if (accept) begin
      if (kind == KIND_ACK_READ) begin
        out_load = 1'b1;
        load_ack = ack_latched;
      end else if (!sctrl.start) begin
        out_load = 1'b1;
      end
    end else if (state == S_SCAN && sstat.done && out_free) begin
      out_load = 1'b1;
      if (sstat.hit) begin
        load_meas  = 1'b1;
        load_tag   = scan_tag;
        load_range = scan_range;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      rd_pos    <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept && (kind == KIND_BYTE)) begin
        len <= is_eol ? '0 : len_next;
      end
      if (sctrl.start) begin
        state  <= S_SCAN;
        rd_pos <= LEN_W'(2);
        pend   <= 1'b0;
      end else if (state == S_SCAN) begin
        pend <= issue;
        if (issue) begin
          rd_pos <= rd_pos + 1'b1;
        end
        if (sstat.done && out_free) begin
          state <= S_IDLE;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sctrl.start) begin
      scan_end <= len;
    end
    if (out_load) begin
      measurement_valid <= load_meas;
      tag_id            <= load_tag;
      range_mm          <= load_range;
      ack_flag          <= load_ack;
    end
  end

endmodule

// ===== design/rlp_checker.sv =====
// port-level checks on the ranging line parser, bound to the top level
// depends on rlp_pkg and ranging_line_parser_macros.svh
`include "ranging_line_parser_macros.svh"

module rlp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         kind,
  input logic [7:0]                   rx_byte,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         measurement_valid,
  input logic [rlp_pkg::TAG_W-1:0]    tag_id,
  input logic [rlp_pkg::RANGE_W-1:0]  range_mm,
  input logic                         ack_flag
);
  import rlp_pkg::*;

  logic in_txn;
  assign in_txn = in_valid && !in_stall;

  // a result held back by the receiver stays offered
  `RLP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // a measurement always carries a nonzero range and never the ack flag
  `RLP_ASSERT_IMP(a_meas_range, clk, rst, out_valid && measurement_valid, (range_mm != '0) && !ack_flag)

  // a result without a measurement has zero tag and range
  `RLP_ASSERT_IMP(a_nomeas_zero, clk, rst, out_valid && !measurement_valid, (tag_id == '0) && (range_mm == '0))

  // an acknowledgement read answers in the next cycle, with no measurement
  `RLP_ASSERT_NEXT(a_ack_read, clk, rst, in_txn && (kind == KIND_ACK_READ), out_valid && !measurement_valid)

endmodule

bind ranging_line_parser rlp_checker u_rlp_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .kind              (kind),
  .rx_byte           (rx_byte),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .measurement_valid (measurement_valid),
  .tag_id            (tag_id),
  .range_mm          (range_mm),
  .ack_flag          (ack_flag)
);
